>>> rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
`default_nettype none
package brf_pkg;

  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_READ_SOME  = 2'd1,
    OP_READ_WHOLE = 2'd2,
    OP_FLUSH      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_OUT
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] count;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/brf_front.sv
// Front end: takes input words, decodes the opcode and queues commands for the back end.
`default_nettype none
module brf_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   opcode,
  input  wire logic [7:0]   data_byte,
  input  wire logic [7:0]   count,
  output logic              cmd_valid,
  input  wire logic         cmd_ready,
  output brf_pkg::cmd_t     cmd
);
  import brf_pkg::*;

  localparam int QD = 2;

  cmd_t       q [QD];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op    = op_t'(opcode);
    cmd_in.data  = data_byte;
    cmd_in.count = count;
  end

  assign in_ready  = (fill != 2'(QD));
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_idx];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_idx] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= ~wr_idx;
      end
      if (pop) begin
        rd_idx <= ~rd_idx;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/brf_back.sv
// Back end: ring store, pointers and the sequencer that emits result words.
`default_nettype none
module brf_back #(
  parameter int DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire brf_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               has_byte,
  output logic [1:0]         status,
  output logic               last
);
  import brf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;

  back_state_t       state, state_next;
  logic [PW-1:0]     wptr, wptr_next;
  logic [PW-1:0]     rptr, rptr_next;
  logic [7:0]        remain, remain_next;
  logic [1:0]        status_next;
  logic              has_byte_next;
  logic              last_next;
  logic [PW-1:0]     fill;
  logic [7:0]        fill8;
  logic [PW-1:0]     wptr_inc;
  logic [PW-1:0]     rptr_inc;
  logic              mem_we;
  logic              mem_re;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wptr_inc = ptr_inc(wptr);
  assign rptr_inc = ptr_inc(rptr);
  assign fill     = (wptr >= rptr) ? wptr - rptr : PW'(DEPTH) + wptr - rptr;
  assign fill8    = 8'(fill);

  assign cmd_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_byte  = has_byte ? rd_data : '0;

  always_comb begin
    state_next    = state;
    wptr_next     = wptr;
    rptr_next     = rptr;
    remain_next   = remain;
    status_next   = status;
    has_byte_next = has_byte;
    last_next     = last;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          has_byte_next = 1'b0;
          last_next     = 1'b1;
          status_next   = ST_OK;
          state_next    = S_OUT;
          unique case (cmd.op)
            OP_WRITE: begin
              if (wptr_inc == rptr) begin
                status_next = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                wptr_next = wptr_inc;
              end
            end
            OP_READ_SOME: begin
              if (fill == '0) begin
                status_next = ST_EMPTY;
              end else if (cmd.count != 8'd0) begin
                remain_next = (cmd.count < fill8) ? cmd.count : fill8;
                state_next  = S_FETCH;
              end
            end
            OP_READ_WHOLE: begin
              if (fill == '0) begin
                status_next = ST_EMPTY;
              end else if (fill8 > cmd.count) begin
                status_next = ST_TOO_SMALL;
              end else begin
                remain_next = fill8;
                state_next  = S_FETCH;
              end
            end
            OP_FLUSH: begin
              wptr_next = '0;
              rptr_next = '0;
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_FETCH: begin
        // read the oldest byte, advance the read pointer
        mem_re        = 1'b1;
        rptr_next     = rptr_inc;
        remain_next   = remain - 8'd1;
        has_byte_next = 1'b1;
        status_next   = ST_OK;
        last_next     = (remain == 8'd1);
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr] <= cmd.data;
    end
    if (mem_re) begin
      rd_data <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr  <= '0;
      rptr  <= '0;
    end else begin
      state <= state_next;
      wptr  <= wptr_next;
      rptr  <= rptr_next;
    end
  end

  always_ff @(posedge clk) begin
    remain   <= remain_next;
    status   <= status_next;
    has_byte <= has_byte_next;
    last     <= last_next;
  end

endmodule
`default_nettype wire

>>> rtl/byte_ring_fifo.sv
// Byte ring FIFO: an accepted input word is registered in the front-end command queue; the
// back-end sequencer then takes it and registers a single-word result in its output registers.
// A read first enters the fetch state, which registers the store read, and each further byte
// again passes the fetch state (store read, then output register). A 2-entry command queue
// lets the front keep accepting while the back end works or the output stalls.
// Synchronous reset clears pointers, queue and sequencer; store contents stay undefined.
`default_nettype none
module byte_ring_fifo #(
  parameter int DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] count,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic [1:0]      status,
  output logic            last
);
  import brf_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  brf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .data_byte (data_byte),
    .count     (count),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .status    (status),
    .last      (last)
  );

endmodule
`default_nettype wire

>>> rtl/brf_checker.sv
// Port-level checks for the byte ring FIFO and their binding to the top level.
`default_nettype none
module brf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       has_byte,
  input wire logic [1:0] status,
  input wire logic       last
);
  import brf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_byte, has_byte, status, last}))
    else $error("result word changed while stalled");

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> status == ST_OK)
    else $error("byte word with non-ok status");

  a_nobyte_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last)
    else $error("status-only word is not final");

  a_nobyte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_byte == 8'd0)
    else $error("status-only word carries data");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (.*);
`default_nettype wire
